// File: rtl/core/b2b_pkg.sv
// package: constants, types and functions shared by the blake2b engine
`default_nettype none
package b2b_pkg;
    localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0000;
    localparam logic [7:0] DEFAULT_ROUNDS = 8'd12;
    localparam logic [63:0] FINAL_FLAG = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [7:0] BLOCK_BYTES = 8'd128;
    localparam logic [0:0] REG_ROUND_COUNT = 1'b0;
    localparam logic [0:0] REG_DIGEST_LENGTH = 1'b1;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic       init_chain;
        logic       load_word;
        logic       clear_tail;
        logic [3:0] tail_index;
        logic       start_comp;
        logic       final_flag;
        logic       add_count;
        logic [7:0] count_add;
    } t_dp_cmd;

    typedef struct packed {
        logic comp_busy;
        logic count_zero;
    } t_dp_status;

    function automatic t_word iv_word(input logic [2:0] idx);
        case (idx)
            3'd0: iv_word = 64'h6A09E667F3BCC908;
            3'd1: iv_word = 64'hBB67AE8584CAA73B;
            3'd2: iv_word = 64'h3C6EF372FE94F82B;
            3'd3: iv_word = 64'hA54FF53A5F1D36F1;
            3'd4: iv_word = 64'h510E527FADE682D1;
            3'd5: iv_word = 64'h9B05688C2B3E6C1F;
            3'd6: iv_word = 64'h1F83D9ABFB41BD6B;
            default: iv_word = 64'h5BE0CD19137E2179;
        endcase
    endfunction

    function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] pos);
        logic [63:0] r;
        case (row)
            4'd0: r = 64'hFEDCBA9876543210;
            4'd1: r = 64'h357B20C16DF984AE;
            4'd2: r = 64'h491763EADF250C8B;
            4'd3: r = 64'h8F04A562EBCD1397;
            4'd4: r = 64'hD386CB1EFA427509;
            4'd5: r = 64'h91EF57D438B0A6C2;
            4'd6: r = 64'hB8293670A4DEF15C;
            4'd7: r = 64'hA2684F05931CE7BD;
            4'd8: r = 64'h5A417D2C803B9EF6;
            default: r = 64'h0DC3E9BF5167482A;
        endcase
        sigma = r[{pos, 2'b00} +: 4];
    endfunction

    function automatic t_word rotr(input t_word v, input int unsigned n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/b2b_if.sv
// valid/ready channel interfaces for message, digest and configuration transfers
`default_nettype none
interface b2b_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_item;
    modport source (output valid, message_word, byte_count, last_item, input ready);
    modport sink (input valid, message_word, byte_count, last_item, output ready);
endinterface

interface b2b_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [3:0]  digest_bytes;
    logic        last_word;
    modport source (output valid, digest_word, digest_bytes, last_word, input ready);
    modport sink (input valid, digest_word, digest_bytes, last_word, output ready);
endinterface

interface b2b_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [7:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/b2b_datapath.sv
// datapath: block buffer, chaining value, byte counter and shared mixing unit
`default_nettype none
module b2b_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire b2b_pkg::t_dp_cmd    i_cmd,
    input  wire logic [63:0]         i_word,
    input  wire logic [7:0]          i_rounds,
    input  wire logic [6:0]          i_digest_length,
    input  wire logic [2:0]          i_read_index,
    output      b2b_pkg::t_word      o_chain_word,
    output      b2b_pkg::t_dp_status o_status
);
    import b2b_pkg::*;

    t_word       r_buf [16];
    t_word       r_h [8];
    t_word       r_v [16];
    logic [63:0] r_cnt_lo;
    logic [63:0] r_cnt_hi;
    logic [3:0]  r_wr;
    logic        r_busy;
    logic        r_half;
    logic [7:0]  r_round;
    logic [7:0]  r_nrounds;
    logic [3:0]  r_srow;
    logic        r_fold;
    t_word       r_pword;
    logic        r_pend;

    t_word n_v [16];
    logic [3:0] ia [4];
    logic [3:0] ib [4];
    logic [3:0] ic [4];
    logic [3:0] id [4];
    logic [64:0] cnt_sum;

    function automatic logic [255:0] gmix(input t_word a, input t_word b, input t_word c,
                                          input t_word d, input t_word m0, input t_word m1);
        t_word ta, tb, tc, td;
        ta = a + b + m0;
        td = rotr(d ^ ta, 32);
        tc = c + td;
        tb = rotr(b ^ tc, 24);
        ta = ta + tb + m1;
        td = rotr(td ^ ta, 16);
        tc = tc + td;
        tb = rotr(tb ^ tc, 63);
        gmix = {ta, tb, tc, td};
    endfunction

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            ia[g] = 4'(g);
            if (!r_half) begin
                ib[g] = 4'(g + 4);
                ic[g] = 4'(g + 8);
                id[g] = 4'(g + 12);
            end else begin
                ib[g] = 4'(((g + 1) % 4) + 4);
                ic[g] = 4'(((g + 2) % 4) + 8);
                id[g] = 4'(((g + 3) % 4) + 12);
            end
        end
        for (int k = 0; k < 16; k++) n_v[k] = r_v[k];
        for (int g = 0; g < 4; g++) begin
            logic [255:0] res;
            logic [3:0] p0, p1;
            p0 = sigma(r_srow, {r_half, 2'(g), 1'b0});
            p1 = sigma(r_srow, {r_half, 2'(g), 1'b1});
            res = gmix(r_v[ia[g]], r_v[ib[g]], r_v[ic[g]], r_v[id[g]], r_buf[p0], r_buf[p1]);
            n_v[ia[g]] = res[255:192];
            n_v[ib[g]] = res[191:128];
            n_v[ic[g]] = res[127:64];
            n_v[id[g]] = res[63:0];
        end
        cnt_sum = {1'b0, r_cnt_lo} + {57'd0, i_cmd.count_add};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_pend <= 1'b0;
            r_wr <= '0;
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            for (int k = 0; k < 8; k++)
                r_h[k] <= iv_word(3'(k)) ^ ((k == 0) ? (PARAM_WORD ^ 64'(i_digest_length)) : 64'd0);
        end else begin
            if (i_cmd.init_chain) begin
                for (int k = 0; k < 8; k++)
                    r_h[k] <= iv_word(3'(k)) ^
                              ((k == 0) ? (PARAM_WORD ^ 64'(i_digest_length)) : 64'd0);
                r_cnt_lo <= '0;
                r_cnt_hi <= '0;
                r_wr <= '0;
            end
            if (i_cmd.load_word) begin
                if (i_cmd.start_comp) begin
                    r_pword <= i_word;
                    r_pend <= 1'b1;
                end else begin
                    r_buf[r_wr] <= i_word;
                    r_wr <= r_wr + 4'd1;
                end
            end
            if (i_cmd.clear_tail)
                r_buf[i_cmd.tail_index] <= '0;
            if (i_cmd.add_count) begin
                r_cnt_lo <= cnt_sum[63:0];
                r_cnt_hi <= r_cnt_hi + 64'(cnt_sum[64]);
            end
            r_fold <= 1'b0;
            if (i_cmd.start_comp) begin
                for (int k = 0; k < 8; k++) begin
                    r_v[k] <= r_h[k];
                    r_v[k + 8] <= iv_word(3'(k));
                end
                r_v[12] <= iv_word(3'd4) ^ (i_cmd.add_count ? cnt_sum[63:0] : r_cnt_lo);
                r_v[13] <= iv_word(3'd5) ^
                           (i_cmd.add_count ? (r_cnt_hi + 64'(cnt_sum[64])) : r_cnt_hi);
                r_v[14] <= iv_word(3'd6) ^ (i_cmd.final_flag ? FINAL_FLAG : 64'd0);
                r_nrounds <= (i_rounds == 8'd0) ? DEFAULT_ROUNDS : i_rounds;
                r_round <= '0;
                r_half <= 1'b0;
                r_srow <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                for (int k = 0; k < 16; k++) r_v[k] <= n_v[k];
                r_half <= ~r_half;
                if (r_half) begin
                    r_srow <= (r_srow == 4'd9) ? 4'd0 : r_srow + 4'd1;
                    r_round <= r_round + 8'd1;
                    if (r_round + 8'd1 == r_nrounds) begin
                        r_busy <= 1'b0;
                        r_fold <= 1'b1;
                    end
                end
            end
            if (r_fold) begin
                for (int k = 0; k < 8; k++)
                    r_h[k] <= r_h[k] ^ r_v[k] ^ r_v[k + 8];
                if (r_pend) begin
                    r_buf[r_wr] <= r_pword;
                    r_wr <= r_wr + 4'd1;
                    r_pend <= 1'b0;
                end
            end
        end
    end

    assign o_chain_word = r_h[i_read_index];
    assign o_status.comp_busy = r_busy | r_fold;
    assign o_status.count_zero = (r_cnt_lo == 64'd0) && (r_cnt_hi == 64'd0);

    a_fold_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fold |-> $past(r_busy)) else $error("fold without compression");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_comp |-> !r_busy) else $error("start while busy");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.load_word) else $error("load during compression");
endmodule
`default_nettype wire

// File: rtl/core/b2b_ctrl.sv
// controller: message intake, padding, compression sequencing and digest output
`default_nettype none
module b2b_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    b2b_msg_if.sink                  msg,
    b2b_dig_if.source                dig,
    b2b_cfg_if.sink                  cfg,
    input  wire b2b_pkg::t_dp_status i_status,
    input  wire b2b_pkg::t_word      i_chain_word,
    output      b2b_pkg::t_dp_cmd    o_cmd,
    output      logic [63:0]         o_word,
    output      logic [7:0]          o_rounds,
    output      logic [6:0]          o_digest_length,
    output      logic [2:0]          o_read_index
);
    import b2b_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_WAIT, S_PAD, S_FINAL, S_OUT, S_HOLD} t_state;

    t_state      r_state;
    logic [7:0]  r_fill;
    logic [7:0]  r_rounds;
    logic [6:0]  r_dlen;
    logic [3:0]  r_pad;
    logic [2:0]  r_k;
    logic [6:0]  r_left;
    logic        r_dvalid;
    logic [63:0] r_dword;
    logic [3:0]  r_dbytes;
    logic        r_dlast;
    logic        r_reinit;
    logic        r_lastpend;

    logic        take;
    logic        full;
    logic [3:0]  nb;
    logic [63:0] masked;
    logic [7:0]  fill_after;
    logic [3:0]  bsel;
    logic [63:0] wmask;
    logic        cfg_take;

    assign full = (r_fill == BLOCK_BYTES);
    assign msg.ready = (r_state == S_IDLE) && !r_reinit;
    assign take = msg.valid && msg.ready;
    assign cfg.ready = 1'b1;
    assign cfg_take = cfg.valid && cfg.ready;

    always_comb begin
        nb = msg.last_item ? ((msg.byte_count > 4'd8) ? 4'd8 : msg.byte_count) : 4'd8;
        masked = msg.message_word;
        for (int b = 0; b < 8; b++)
            if (4'(b) >= nb) masked[8*b +: 8] = 8'd0;
        fill_after = ((nb != 4'd0) ? (full ? 8'd0 : r_fill) + 8'(nb) : r_fill);
        bsel = (r_left > 7'd8) ? 4'd8 : r_left[3:0];
        wmask = i_chain_word;
        for (int b = 0; b < 8; b++)
            if (4'(b) >= bsel) wmask[8*b +: 8] = 8'd0;
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.init_chain = r_reinit;
        if (cfg_take && cfg.index == REG_DIGEST_LENGTH && r_fill == 8'd0 &&
            i_status.count_zero)
            o_cmd.init_chain = 1'b1;
        if (take && nb != 4'd0) begin
            o_cmd.load_word = 1'b1;
            if (full) begin
                o_cmd.start_comp = 1'b1;
                o_cmd.add_count = 1'b1;
                o_cmd.count_add = BLOCK_BYTES;
            end
        end
        if (r_state == S_PAD) begin
            o_cmd.clear_tail = ({1'b0, r_pad} >= 5'((r_fill + 8'd7) >> 3)) ||
                               (r_fill == 8'd0);
            o_cmd.tail_index = r_pad;
            if (r_pad == 4'd15) begin
                o_cmd.add_count = 1'b1;
                o_cmd.count_add = r_fill;
            end
        end
        if (r_state == S_FINAL && !i_status.comp_busy && r_k != 3'd7) begin
            o_cmd.start_comp = 1'b1;
            o_cmd.final_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_rounds <= DEFAULT_ROUNDS;
            r_dlen <= 7'd64;
            r_dvalid <= 1'b0;
            r_reinit <= 1'b0;
            r_pad <= '0;
            r_k <= '0;
            r_left <= '0;
        end else begin
            r_reinit <= 1'b0;
            if (cfg_take) begin
                if (cfg.index == REG_ROUND_COUNT) r_rounds <= cfg.data;
                else r_dlen <= cfg.data[6:0];
            end
            if (dig.valid && dig.ready) r_dvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (!msg.last_item) begin
                            r_fill <= full ? 8'd8 : r_fill + 8'd8;
                            r_state <= full ? S_WAIT : S_IDLE;
                        end else begin
                            r_fill <= fill_after;
                            r_pad <= '0;
                            r_state <= (nb != 4'd0 && full) ? S_WAIT : S_PAD;
                        end
                    end
                end
                S_WAIT: begin
                    if (!i_status.comp_busy && !o_cmd.start_comp)
                        r_state <= r_lastpend ? S_PAD : S_IDLE;
                end
                S_PAD: begin
                    r_pad <= r_pad + 4'd1;
                    if (r_pad == 4'd15) r_state <= S_FINAL;
                end
                S_FINAL: begin
                    if (!i_status.comp_busy && !o_cmd.start_comp && r_k == 3'd7)
                        r_state <= S_FINAL;
                    if (o_cmd.start_comp) r_k <= 3'd7;
                    else if (r_k == 3'd7 && !i_status.comp_busy) begin
                        r_k <= '0;
                        r_left <= (r_dlen > 7'd64) ? 7'd64 : r_dlen;
                        r_state <= ((r_dlen == 7'd0) ? S_HOLD : S_OUT);
                    end
                end
                S_OUT: begin
                    if (!r_dvalid || (dig.valid && dig.ready)) begin
                        r_dvalid <= 1'b1;
                        r_dword <= wmask;
                        r_dbytes <= bsel;
                        r_dlast <= (r_left <= 7'd8);
                        r_left <= r_left - 7'(bsel);
                        r_k <= r_k + 3'd1;
                        if (r_left <= 7'd8) r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    r_k <= '0;
                    r_fill <= '0;
                    r_reinit <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lastpend <= 1'b0;
        else if (take) r_lastpend <= msg.last_item;
    end

    assign o_word = masked;
    assign o_rounds = r_rounds;
    assign o_digest_length = (cfg_take && cfg.index == REG_DIGEST_LENGTH) ? cfg.data[6:0]
                                                                          : r_dlen;
    assign o_read_index = r_k;
    assign dig.valid = r_dvalid;
    assign dig.digest_word = r_dword;
    assign dig.digest_bytes = r_dbytes;
    assign dig.last_word = r_dlast;

    a_no_take_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !take) else $error("intake during digest output");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BLOCK_BYTES) else $error("fill overflow");
    a_dig_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dig.valid && !dig.ready |=> dig.valid) else $error("digest word dropped");
endmodule
`default_nettype wire

// File: rtl/core/blake2b_hash_engine_top.sv
// top level of the blake2b hash engine
// usage:
//   msg channel transfers one 64-bit little-endian message word per item;
//   last_item marks the final word, whose byte_count (0..8) gives its bytes.
//   dig channel returns the digest as up to eight words, last_word on the end.
//   cfg channel writes round_count (index 0) and digest_length (index 1); the user
//   writes them only while the engine is idle, the block itself does not enforce it.
// timing:
//   non-final words transfer one per cycle while intake is open; the word that
//   arrives on a full block starts that block's compression and closes intake
//   until setup, the rounds and the fold are done.
//   after a final word the first digest word follows padding, compression start,
//   the rounds, the fold and readout, plus the compression above if that word
//   arrived on a full block; then one digest word per cycle while the receiver
//   takes them.
// reset: synchronous, active low; chaining value reloads from the IV with
//   the default 64-byte digest, rounds default to twelve.
// a stalled receiver holds the current digest word; intake reopens once S_HOLD and
//   the chaining reinit after the last digest word have passed, transferred or not.
`default_nettype none
module blake2b_hash_engine_top (
    input wire logic i_clk,
    input wire logic i_rst_n,
    b2b_msg_if.sink   msg,
    b2b_dig_if.source dig,
    b2b_cfg_if.sink   cfg
);
    import b2b_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_word      chain_word;
    logic [63:0] word;
    logic [7:0]  rounds;
    logic [6:0]  dlen;
    logic [2:0]  ridx;

    b2b_ctrl u_ctrl (
        .i_clk, .i_rst_n, .msg, .dig, .cfg,
        .i_status(status), .i_chain_word(chain_word), .o_cmd(cmd), .o_word(word),
        .o_rounds(rounds), .o_digest_length(dlen), .o_read_index(ridx)
    );

    b2b_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_word(word), .i_rounds(rounds),
        .i_digest_length(dlen), .i_read_index(ridx), .o_chain_word(chain_word),
        .o_status(status)
    );
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the blake2b hash engine with its own hash predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import b2b_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_msg_item;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_digest_item;

    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    b2b_msg_if msg_ch();
    b2b_dig_if dig_ch();
    b2b_cfg_if cfg_ch();

    blake2b_hash_engine_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .msg     (msg_ch.sink),
        .dig     (dig_ch.source),
        .cfg     (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // hash state held by the predictor
    logic [63:0]  iv_tab [8] = '{64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
                                 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
                                 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
                                 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
    logic [3:0] sched [10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

    logic [63:0]  hash_h [8];
    logic [63:0]  blk [16];
    logic [63:0]  wv [16];
    int           blk_fill;
    logic [127:0] total_bytes;
    logic [7:0]   rounds_reg;
    logic [6:0]   dlen_reg;

    t_msg_item    pending_msgs[$];
    t_digest_item expected_digest[$];
    int           items_queued;
    int           items_taken;
    int           words_checked;
    int           messages_done;
    int           errors;
    int           idle_cycles;

    function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    task automatic mix_g(input int a, input int b, input int c, input int d,
                         input logic [63:0] x, input logic [63:0] y);
        wv[a] = wv[a] + wv[b] + x;
        wv[d] = ror64(wv[d] ^ wv[a], 32);
        wv[c] = wv[c] + wv[d];
        wv[b] = ror64(wv[b] ^ wv[c], 24);
        wv[a] = wv[a] + wv[b] + y;
        wv[d] = ror64(wv[d] ^ wv[a], 16);
        wv[c] = wv[c] + wv[d];
        wv[b] = ror64(wv[b] ^ wv[c], 63);
    endtask

    task automatic compress_block(input logic [63:0] flag);
        int nr;
        int s;
        nr = (rounds_reg == 8'd0) ? 12 : int'(rounds_reg);
        s = 0;
        for (int k = 0; k < 8; k++) begin
            wv[k] = hash_h[k];
            wv[k + 8] = iv_tab[k];
        end
        wv[12] ^= total_bytes[63:0];
        wv[13] ^= total_bytes[127:64];
        wv[14] ^= flag;
        for (int r = 0; r < nr; r++) begin
            mix_g(0, 4, 8, 12, blk[sched[s][0]], blk[sched[s][1]]);
            mix_g(1, 5, 9, 13, blk[sched[s][2]], blk[sched[s][3]]);
            mix_g(2, 6, 10, 14, blk[sched[s][4]], blk[sched[s][5]]);
            mix_g(3, 7, 11, 15, blk[sched[s][6]], blk[sched[s][7]]);
            mix_g(0, 5, 10, 15, blk[sched[s][8]], blk[sched[s][9]]);
            mix_g(1, 6, 11, 12, blk[sched[s][10]], blk[sched[s][11]]);
            mix_g(2, 7, 8, 13, blk[sched[s][12]], blk[sched[s][13]]);
            mix_g(3, 4, 9, 14, blk[sched[s][14]], blk[sched[s][15]]);
            s = (s == 9) ? 0 : s + 1;
        end
        for (int k = 0; k < 8; k++) hash_h[k] ^= wv[k] ^ wv[k + 8];
    endtask

    task automatic start_hash();
        for (int k = 0; k < 8; k++) hash_h[k] = iv_tab[k];
        hash_h[0] ^= PARAM_WORD ^ {57'd0, dlen_reg};
        blk_fill = 0;
        total_bytes = '0;
    endtask

    task automatic buffer_word(input logic [63:0] word, input int nb);
        if (nb != 0) begin
            if (blk_fill >= 128) begin
                total_bytes += 128;
                compress_block(64'd0);
                blk_fill = 0;
            end
            if (nb < 8) word &= (64'd1 << (8 * nb)) - 64'd1;
            blk[blk_fill / 8] = word;
            blk_fill += 8;
        end
    endtask

    task automatic absorb_item(input t_msg_item it);
        int nb;
        int len;
        int nres;
        t_digest_item d;
        if (!it.last) begin
            buffer_word(it.word, 8);
        end else begin
            nb = (it.nbytes > 8) ? 8 : int'(it.nbytes);
            buffer_word(it.word, nb);
            if (nb != 0 && nb < 8) blk_fill -= 8 - nb;
            total_bytes += blk_fill;
            for (int k = (blk_fill + 7) / 8; k < 16; k++) blk[k] = '0;
            compress_block(FINAL_FLAG);
            len = (dlen_reg > 64) ? 64 : int'(dlen_reg);
            nres = (len + 7) / 8;
            for (int k = 0; k < nres; k++) begin
                d.nbytes = (len - 8 * k > 8) ? 4'd8 : 4'(len - 8 * k);
                d.word = hash_h[k];
                if (d.nbytes < 8) d.word &= (64'd1 << (8 * d.nbytes)) - 64'd1;
                d.last = (k + 1 == nres);
                expected_digest.push_back(d);
            end
            messages_done++;
            start_hash();
        end
    endtask

    // message driver
    int msg_gap;
    always @(posedge i_clk) begin
        t_msg_item it;
        if (!i_rst_n) begin
            msg_ch.valid <= 1'b0;
            msg_gap <= 0;
        end else if (!msg_ch.valid || msg_ch.ready) begin
            if (msg_gap > 0) begin
                msg_gap <= msg_gap - 1;
                msg_ch.valid <= 1'b0;
            end else if (pending_msgs.size() > 0) begin
                it = pending_msgs.pop_front();
                msg_ch.message_word <= it.word;
                msg_ch.byte_count <= it.nbytes;
                msg_ch.last_item <= it.last;
                msg_ch.valid <= 1'b1;
                msg_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end else begin
                msg_ch.valid <= 1'b0;
            end
        end
    end

    // digest receiver with random stalls
    int dig_stall;
    always @(posedge i_clk) begin
        int st;
        if (!i_rst_n) begin
            dig_ch.ready <= 1'b0;
            dig_stall <= 0;
        end else begin
            st = dig_stall;
            if (dig_ch.valid && dig_ch.ready)
                st = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (st > 0) begin
                dig_ch.ready <= 1'b0;
                dig_stall <= st - 1;
            end else begin
                dig_ch.ready <= 1'b1;
                dig_stall <= 0;
            end
        end
    end

    // monitor: predictor update on every transfer, digest check
    always @(posedge i_clk) begin
        t_msg_item it;
        t_digest_item e;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_ROUND_COUNT) begin
                    rounds_reg = cfg_ch.data;
                end else begin
                    dlen_reg = cfg_ch.data[6:0];
                    if (blk_fill == 0 && total_bytes == '0) start_hash();
                end
            end
            if (msg_ch.valid && msg_ch.ready) begin
                it.word = msg_ch.message_word;
                it.nbytes = msg_ch.byte_count;
                it.last = msg_ch.last_item;
                absorb_item(it);
                items_taken++;
            end
            if (dig_ch.valid && dig_ch.ready) begin
                if (expected_digest.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected digest word, expected none, actual %h",
                             $time, dig_ch.digest_word);
                end else begin
                    e = expected_digest.pop_front();
                    words_checked++;
                    if (dig_ch.digest_word !== e.word) begin
                        errors++;
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, e.word, dig_ch.digest_word);
                    end
                    if (dig_ch.digest_bytes !== e.nbytes) begin
                        errors++;
                        $display("%0t: digest_bytes expected %0d actual %0d",
                                 $time, e.nbytes, dig_ch.digest_bytes);
                    end
                    if (dig_ch.last_word !== e.last) begin
                        errors++;
                        $display("%0t: last_word expected %0d actual %0d",
                                 $time, e.last, dig_ch.last_word);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(input logic [63:0] w, input logic [3:0] nb, input logic last);
        t_msg_item it;
        it.word = w;
        it.nbytes = nb;
        it.last = last;
        pending_msgs.push_back(it);
        items_queued++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic push_message(input int nwords, input logic [3:0] tail_nb);
        for (int k = 0; k < nwords; k++) push_item(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        push_item(rand_word(), tail_nb, 1'b1);
    endtask

    task automatic drain();
        wait (items_taken == items_queued && expected_digest.size() == 0);
        repeat (2 * ((rounds_reg == 0) ? 12 : int'(rounds_reg)) + 60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_messages(input int budget);
        int n;
        while (budget > 0) begin
            case ($urandom_range(0, 7))
                0: n = 15;
                1: n = 16;
                2: n = 32;
                default: n = $urandom_range(0, 20);
            endcase
            push_message(n, 4'($urandom_range(0, 15)));
            budget -= n + 1;
        end
    endtask

    initial begin
        msg_ch.valid = 1'b0;
        msg_ch.message_word = '0;
        msg_ch.byte_count = '0;
        msg_ch.last_item = 1'b0;
        dig_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ROUND_COUNT;
        cfg_ch.data = '0;
        items_queued = 0;
        items_taken = 0;
        words_checked = 0;
        messages_done = 0;
        errors = 0;
        idle_cycles = 0;
        rounds_reg = DEFAULT_ROUNDS;
        dlen_reg = 7'd64;
        start_hash();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, partial tails, an over-range byte count, multi-word messages
        push_item(64'd0, 4'd0, 1'b1);
        push_item('1, 4'd1, 1'b1);
        push_item(64'h0123456789ABCDEF, 4'd7, 1'b1);
        push_item('1, 4'd8, 1'b1);
        push_item('1, 4'd15, 1'b1);
        push_message(15, 4'd0);
        push_message(1, 4'd3);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd0);
        write_reg(REG_DIGEST_LENGTH, 8'd32);
        push_message(16, 4'd8);
        random_messages(60);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd1);
        write_reg(REG_DIGEST_LENGTH, 8'd1);
        random_messages(60);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd255);
        write_reg(REG_DIGEST_LENGTH, 8'd127);
        push_message(3, 4'd5);
        push_message(0, 4'd2);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd7);
        write_reg(REG_DIGEST_LENGTH, 8'd0);
        push_message(2, 4'd4);
        drain();

        write_reg(REG_DIGEST_LENGTH, 8'd17);
        random_messages(60);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd200);
        write_reg(REG_DIGEST_LENGTH, 8'd8);
        random_messages(20);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd12);
        write_reg(REG_DIGEST_LENGTH, 8'd64);
        random_messages(140);
        drain();

        write_reg(REG_ROUND_COUNT, 8'd13);
        write_reg(REG_DIGEST_LENGTH, 8'd45);
        random_messages(60);
        drain();

        $display("%0d message items in %0d messages, %0d digest words checked, %0d errors",
                 items_taken, messages_done, words_checked, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
